/* hdl/shiprr_pkg.sv */
package shiprr_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CMD_W     = 1;
  localparam int SET_IDX_W = 11;
  localparam int WAY_IDX_W = 4;
  localparam int PC_W      = 32;
  localparam int VICTIM_W  = 4;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Per-block and per-signature state widths.
  localparam int RV_W  = 2;
  localparam int CTR_W = 2;

  localparam logic [RV_W-1:0]  RV_MAX     = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MAX    = 2'd3;
  localparam logic [CTR_W-1:0] CTR_RESET  = 2'd2;
  localparam logic [CTR_W-1:0] THR_RESET  = 2'd2;

  // Shift amounts of the program counter fold.
  localparam int FOLD_A = 12;
  localparam int FOLD_B = 20;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_VICTIM = 1'b0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b1;

  // Register decode on the word-address bit of paddr.
  localparam logic REG_THRESHOLD = 1'b0;

endpackage

/* hdl/shiprr_ram.sv */
module shiprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/shiprr_mod.sv */
module shiprr_mod #(
  parameter int IN_W  = 32,
  parameter int MOD   = 4096,
  parameter int OUT_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  value,
  output logic             done,
  output logic [OUT_W-1:0] result
);

  // Restoring remainder, four dividend bits per cycle from the top down.
  localparam int STEPS = (IN_W + 3) / 4;
  localparam int PW    = STEPS * 4;
  localparam int RW    = $clog2(MOD) + 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [PW-1:0] val_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  always_comb begin
    rem_nxt = rem_r;
    for (int k = 0; k < 4; k++) begin
      rem_nxt = {rem_nxt[RW-2:0], val_r[PW-1-k]};
      if (rem_nxt >= RW'(MOD)) begin
        rem_nxt = rem_nxt - RW'(MOD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        val_r  <= PW'(value);
        rem_r  <= '0;
        cnt_r  <= CW'(STEPS - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        val_r <= val_r << 4;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = OUT_W'(rem_r);

endmodule

/* hdl/ship_rrip_replacement.sv */
// Signature-based RRIP replacement for a set-associative cache.
// Requests enter on in_valid/in_stall. A victim query (cmd 0) returns one
// result on out_valid/out_stall carrying the way to evict; a hit or fill
// report (cmd 1) returns nothing. One request is worked on at a time.
// Set rows live in one RAM (one row per set, every way side by side) and
// the reuse counters in a second RAM; each request is a read, modify and
// write-back of its row (a victim query writes only when the ways age), and
// a hit or fill report also updates one counter entry; a fill then reads the
// new signature's counter. Both RAMs have registered reads.
// When NUM_SETS is neither a power of two nor at least 2048, the set index
// passes through a remainder unit first (4 bits a cycle); a COUNTER_ENTRIES
// that is not a power of two sends a fill's signature through a second one.
// The result register holds a victim until it is taken; the next request is
// still accepted, and a following victim query waits for the register.
// After reset the block clears both RAMs, one row and one counter entry per
// cycle, until its clear counter has passed the larger depth of the two,
// with in_stall high. The threshold register can be written during that time.
module ship_rrip_replacement import shiprr_pkg::*; #(
  parameter int NUM_SETS        = 2048,
  parameter int NUM_WAYS        = 16,
  parameter int COUNTER_ENTRIES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [SET_IDX_W-1:0] in_set_index,
  input  logic [WAY_IDX_W-1:0] in_way_index,
  input  logic [PC_W-1:0]      in_load_pc,
  input  logic                 in_was_hit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VICTIM_W-1:0]  out_victim_way,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int SIG_W  = $clog2(COUNTER_ENTRIES);
  localparam int ENT_W  = RV_W + 1 + SIG_W;
  localparam int ROW_W  = NUM_WAYS * ENT_W;
  localparam bit SET_POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam bit SET_DIRECT = SET_POW2 || (NUM_SETS >= (1 << SET_IDX_W));
  localparam bit SIG_POW2   = (COUNTER_ENTRIES & (COUNTER_ENTRIES - 1)) == 0;
  localparam int CLR_N  = (NUM_SETS > COUNTER_ENTRIES) ? NUM_SETS : COUNTER_ENTRIES;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SMOD,
    ST_ROW,
    ST_CRD1,
    ST_FMOD,
    ST_SIG,
    ST_CRD2
  } state_t;

  state_t               state_r;
  logic [CLR_W-1:0]     clr_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [SET_W-1:0]     set_r;
  logic [WAY_W-1:0]     way_r;
  logic [PC_W-1:0]      pc_r;
  logic                 hit_r;
  logic                 out_valid_r;
  logic [VICTIM_W-1:0]  out_victim_r;
  logic [CTR_W-1:0]     thr_r;

  logic                 out_free;
  logic                 out_load;
  logic                 clr_in_sets;
  logic                 clr_in_ctrs;
  logic [SET_W-1:0]     set_in_direct;
  logic [PC_W-1:0]      fold;
  logic [SIG_W-1:0]     sig_new;

  logic                 set_mod_start;
  logic                 set_mod_done;
  logic [SET_W-1:0]     set_mod_res;
  logic                 sig_mod_start;
  logic                 sig_mod_done;
  logic [SIG_W-1:0]     sig_mod_res;

  logic                 set_we;
  logic [SET_W-1:0]     set_waddr;
  logic [ROW_W-1:0]     set_wdata;
  logic                 set_re;
  logic [SET_W-1:0]     set_raddr;
  logic [ROW_W-1:0]     set_rdata;

  logic                 ctr_we;
  logic [SIG_W-1:0]     ctr_waddr;
  logic [CTR_W-1:0]     ctr_wdata;
  logic                 ctr_re;
  logic [SIG_W-1:0]     ctr_raddr;
  logic [CTR_W-1:0]     ctr_rdata;

  logic [ENT_W-1:0]     old_ent;
  logic                 old_reused;
  logic [SIG_W-1:0]     old_sig;
  logic [ROW_W-1:0]     clear_row;
  logic [ROW_W-1:0]     aged_row;
  logic [ROW_W-1:0]     hit_row;
  logic [ROW_W-1:0]     fill_row;
  logic [RV_W-1:0]      top_rv;
  logic [RV_W-1:0]      lift;
  logic [WAY_W-1:0]     victim_w;
  logic [CTR_W-1:0]     ctr_up;
  logic [CTR_W-1:0]     ctr_dn;
  logic [RV_W-1:0]      ins_rv;

  function automatic logic [WAY_W-1:0] way_mod(input logic [WAY_IDX_W-1:0] w);
    logic [WAY_W+1:0] r;
    r = '0;
    for (int k = WAY_IDX_W - 1; k >= 0; k--) begin
      r = {r[WAY_W:0], w[k]};
      if (r >= (WAY_W + 2)'(NUM_WAYS)) begin
        r = r - (WAY_W + 2)'(NUM_WAYS);
      end
    end
    return r[WAY_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) begin
      thr_r <= pwdata[CTR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? CFG_DW'(thr_r) : '0;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------
  // Index mapping
  // ---------------------------------------------------------------------
  assign set_in_direct = SET_POW2 ? (SET_W'(in_set_index) & SET_MASK)
                                  : SET_W'(in_set_index);
  assign fold    = pc_r ^ (pc_r >> FOLD_A) ^ (pc_r >> FOLD_B);
  assign sig_new = SIG_POW2 ? fold[SIG_W-1:0] : sig_mod_res;

  assign set_mod_start = (state_r == ST_IDLE) && in_valid && !SET_DIRECT;
  assign sig_mod_start = (state_r == ST_CRD1) && !hit_r && !SIG_POW2;

  shiprr_mod #(
    .IN_W (SET_IDX_W),
    .MOD  (NUM_SETS),
    .OUT_W(SET_W)
  ) u_set_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (set_mod_start),
    .value (in_set_index),
    .done  (set_mod_done),
    .result(set_mod_res)
  );

  shiprr_mod #(
    .IN_W (PC_W),
    .MOD  (COUNTER_ENTRIES),
    .OUT_W(SIG_W)
  ) u_sig_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sig_mod_start),
    .value (fold),
    .done  (sig_mod_done),
    .result(sig_mod_res)
  );

  // ---------------------------------------------------------------------
  // Row update logic
  // ---------------------------------------------------------------------
  assign old_ent    = set_rdata[way_r*ENT_W +: ENT_W];
  assign old_reused = old_ent[RV_W];
  assign old_sig    = old_ent[ENT_W-1:RV_W+1];

  always_comb begin
    logic any3;
    logic any2;
    logic any1;
    logic [RV_W-1:0] rv;
    any3      = 1'b0;
    any2      = 1'b0;
    any1      = 1'b0;
    clear_row = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rv   = set_rdata[w*ENT_W +: RV_W];
      any3 = any3 | (rv == 2'd3);
      any2 = any2 | (rv == 2'd2);
      any1 = any1 | (rv == 2'd1);
      clear_row[w*ENT_W +: RV_W] = RV_MAX;
    end
    top_rv = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    lift   = RV_MAX - top_rv;
    // Adding the lift to every way brings the largest value to the maximum,
    // so the victim is the lowest way that held the largest value.
    aged_row = set_rdata;
    victim_w = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      rv = set_rdata[w*ENT_W +: RV_W];
      aged_row[w*ENT_W +: RV_W] = rv + lift;
      if (rv == top_rv) begin
        victim_w = WAY_W'(w);
      end
    end
  end

  assign ctr_up = (ctr_rdata == CTR_MAX) ? ctr_rdata : ctr_rdata + 1'b1;
  assign ctr_dn = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - 1'b1;

  always_comb begin
    if (ctr_rdata == '0) begin
      ins_rv = RV_MAX;
    end else if (ctr_rdata < thr_r) begin
      ins_rv = RV_MAX - 1'b1;
    end else begin
      ins_rv = '0;
    end
  end

  always_comb begin
    hit_row  = set_rdata;
    fill_row = set_rdata;
    hit_row[way_r*ENT_W +: ENT_W]  = {old_sig, 1'b1, {RV_W{1'b0}}};
    fill_row[way_r*ENT_W +: ENT_W] = {sig_new, 1'b0, ins_rv};
  end

  // ---------------------------------------------------------------------
  // Memory port control
  // ---------------------------------------------------------------------
  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == ST_ROW) && (cmd_r == CMD_VICTIM) && out_free;
  assign clr_in_sets = {1'b0, clr_r} < (CLR_W + 1)'(NUM_SETS);
  assign clr_in_ctrs = {1'b0, clr_r} < (CLR_W + 1)'(COUNTER_ENTRIES);

  always_comb begin
    set_we    = 1'b0;
    set_waddr = set_r;
    set_wdata = aged_row;
    set_re    = 1'b0;
    set_raddr = set_in_direct;
    ctr_we    = 1'b0;
    ctr_waddr = old_sig;
    ctr_wdata = (hit_r || old_reused) ? ctr_up : ctr_dn;
    ctr_re    = 1'b0;
    ctr_raddr = old_sig;
    unique case (state_r)
      ST_CLEAR: begin
        set_we    = clr_in_sets;
        set_waddr = clr_r[SET_W-1:0];
        set_wdata = clear_row;
        ctr_we    = clr_in_ctrs;
        ctr_waddr = clr_r[SIG_W-1:0];
        ctr_wdata = CTR_RESET;
      end
      ST_IDLE: begin
        set_re = in_valid && SET_DIRECT;
      end
      ST_SMOD: begin
        set_re    = set_mod_done;
        set_raddr = set_mod_res;
      end
      ST_ROW: begin
        set_we = (cmd_r == CMD_VICTIM) && out_free && (lift != '0);
        ctr_re = (cmd_r == CMD_UPDATE);
      end
      ST_CRD1: begin
        set_we    = hit_r;
        set_wdata = hit_row;
        ctr_we    = 1'b1;
      end
      ST_FMOD: begin
        ctr_re    = sig_mod_done;
        ctr_raddr = sig_new;
      end
      ST_SIG: begin
        ctr_re    = 1'b1;
        ctr_raddr = sig_new;
      end
      ST_CRD2: begin
        set_we    = 1'b1;
        set_wdata = fill_row;
      end
      default: begin
        set_we = 1'b0;
      end
    endcase
  end

  shiprr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_set_ram (
    .clk  (clk),
    .we   (set_we),
    .waddr(set_waddr),
    .wdata(set_wdata),
    .re   (set_re),
    .raddr(set_raddr),
    .rdata(set_rdata)
  );

  shiprr_ram #(
    .WIDTH(CTR_W),
    .DEPTH(COUNTER_ENTRIES)
  ) u_ctr_ram (
    .clk  (clk),
    .we   (ctr_we),
    .waddr(ctr_waddr),
    .wdata(ctr_wdata),
    .re   (ctr_re),
    .raddr(ctr_raddr),
    .rdata(ctr_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_cmd;
            way_r   <= way_mod(in_way_index);
            pc_r    <= in_load_pc;
            hit_r   <= in_was_hit;
            set_r   <= set_in_direct;
            state_r <= SET_DIRECT ? ST_ROW : ST_SMOD;
          end
        end
        ST_SMOD: begin
          if (set_mod_done) begin
            set_r   <= set_mod_res;
            state_r <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (cmd_r == CMD_VICTIM) begin
            // The row read stays in the RAM output while the result waits.
            if (out_free) begin
              out_victim_r <= VICTIM_W'(victim_w);
              state_r      <= ST_IDLE;
            end
          end else begin
            state_r <= ST_CRD1;
          end
        end
        ST_CRD1: begin
          if (hit_r) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= SIG_POW2 ? ST_SIG : ST_FMOD;
          end
        end
        ST_FMOD: begin
          if (sig_mod_done) begin
            state_r <= ST_CRD2;
          end
        end
        ST_SIG: begin
          state_r <= ST_CRD2;
        end
        ST_CRD2: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_victim_way = out_victim_r;

endmodule

/* hdl/shiprr_chk.sv */
module shiprr_chk import shiprr_pkg::*; #(
  parameter int NUM_WAYS = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [CMD_W-1:0]     in_cmd,
  input logic [SET_IDX_W-1:0] in_set_index,
  input logic [WAY_IDX_W-1:0] in_way_index,
  input logic [PC_W-1:0]      in_load_pc,
  input logic                 in_was_hit,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [VICTIM_W-1:0]  out_victim_way,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [CFG_AW-1:0]    paddr,
  input logic [CFG_DW-1:0]    pwdata,
  input logic [CFG_DW-1:0]    prdata,
  input logic                 pready
);

  // A stalled result keeps its way.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_victim_way))
    else $error("victim result changed while stalled");

  // An accepted request raises in_stall, so requests are never taken back to back.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in back-to-back cycles");

  // Reset drops the result and holds off requests during the clearing pass.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

  // The victim names a way that exists.
  a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (NUM_WAYS > 16) || (int'(out_victim_way) < NUM_WAYS))
    else $error("victim way beyond the set");

  // A threshold write reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)
    |=> (paddr[2] != REG_THRESHOLD) || (prdata[CTR_W-1:0] == $past(pwdata[CTR_W-1:0])))
    else $error("threshold register did not take the write");

endmodule

bind ship_rrip_replacement shiprr_chk #(.NUM_WAYS(NUM_WAYS)) u_shiprr_chk (.*);
